// ----- rtl/ftsg_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
package ftsg_pkg;
	localparam int XW = 8;
	localparam int YW = 6;
	localparam int CW = 32;
	localparam int SW = 15;

	// One sorted triangle handed from the front part to the back part.
	typedef struct packed {
		logic [XW-1:0] ax;
		logic [YW-1:0] ay;
		logic [XW-1:0] bx;
		logic [YW-1:0] by;
		logic [XW-1:0] cx;
		logic [YW-1:0] cy;
		logic [CW-1:0] color;
	} tri_t;

	typedef enum logic [2:0] {
		BK_IDLE,
		BK_DIV,
		BK_PREP,
		BK_UPPER,
		BK_LOWER
	} bk_state_t;
endpackage
`default_nettype wire

// ----- rtl/ftsg_front.sv -----
`timescale 1ns / 1ps
`default_nettype none
module ftsg_front
	import ftsg_pkg::*;
(
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          in_valid,
	output logic               in_stall,
	input  wire logic [XW-1:0] vert0_x,
	input  wire logic [YW-1:0] vert0_y,
	input  wire logic [XW-1:0] vert1_x,
	input  wire logic [YW-1:0] vert1_y,
	input  wire logic [XW-1:0] vert2_x,
	input  wire logic [YW-1:0] vert2_y,
	input  wire logic [CW-1:0] fill_color,
	output logic               q_valid,
	input  wire logic          q_take,
	output tri_t               q_data
);
	// two-entry queue of sorted triangles
	tri_t       mem_q [2];
	logic       wp_q, rp_q;
	logic [1:0] cnt_q;
	tri_t       srt;
	logic [1:0] a, b, c;
	logic       push;
	logic [XW-1:0] xs [3];
	logic [YW-1:0] ys [3];

	assign xs[0] = vert0_x; assign xs[1] = vert1_x; assign xs[2] = vert2_x;
	assign ys[0] = vert0_y; assign ys[1] = vert1_y; assign ys[2] = vert2_y;

	always_comb begin
		if (vert0_y < vert1_y) begin
			if (vert0_y < vert2_y) begin
				a = 2'd0;
				if (vert1_y < vert2_y) begin b = 2'd1; c = 2'd2; end
				else begin b = 2'd2; c = 2'd1; end
			end else begin
				a = 2'd2; b = 2'd0; c = 2'd1;
			end
		end else begin
			if (vert1_y < vert2_y) begin
				a = 2'd1;
				if (vert0_y < vert2_y) begin b = 2'd0; c = 2'd2; end
				else begin b = 2'd2; c = 2'd0; end
			end else begin
				a = 2'd2; b = 2'd1; c = 2'd0;
			end
		end
		srt.ax = xs[a]; srt.ay = ys[a];
		srt.bx = xs[b]; srt.by = ys[b];
		srt.cx = xs[c]; srt.cy = ys[c];
		srt.color = fill_color;
	end

	assign in_stall = (cnt_q == 2'd2);
	assign push     = in_valid && !in_stall;
	assign q_valid  = (cnt_q != 2'd0);
	assign q_data   = mem_q[rp_q];

	always_ff @(posedge clk) begin
		if (push) mem_q[wp_q] <= srt;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) wp_q <= ~wp_q;
			if (q_take) rp_q <= ~rp_q;
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, q_take};
		end
	end

	a_no_over: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q != 2'd3) else $error("queue count overflow");
	a_take_valid: assert property (@(posedge clk) disable iff (!arst_n)
		q_take |-> q_valid) else $error("pop from empty queue");
	a_full_stall: assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_q == 2'd2 && !q_take) |=> in_stall) else $error("full queue not stalled");
endmodule
`default_nettype wire

// ----- rtl/ftsg_div.sv -----
`timescale 1ns / 1ps
`default_nettype none
// Signed restoring divider, one quotient bit a cycle, truncating toward zero.
module ftsg_div #(
	parameter int NW = 17,
	parameter int DW = 7
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 start,
	input  wire logic signed [NW-1:0] num,
	input  wire logic        [DW-1:0] den,
	output logic                      done,
	output logic signed [NW-1:0]      quo
);
	localparam int CNW = $clog2(NW + 1);
	logic [NW-1:0]  n_q, qt_q;
	logic [DW:0]    rem_q;
	logic [DW-1:0]  d_q;
	logic           neg_q, busy_q;
	logic [CNW-1:0] cnt_q;
	logic [DW:0]    sh;
	logic [DW:0]    df;

	assign sh   = {rem_q[DW-1:0], n_q[NW-1]};
	assign df   = sh - {1'b0, d_q};
	assign done = busy_q && (cnt_q == '0);
	assign quo  = neg_q ? -$signed(qt_q) : $signed(qt_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= CNW'(NW);
		end else if (done) begin
			busy_q <= 1'b0;
		end else if (busy_q) begin
			cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			n_q   <= num[NW-1] ? NW'(-num) : NW'(num);
			neg_q <= num[NW-1];
			d_q   <= den;
			rem_q <= '0;
			qt_q  <= '0;
		end else if (busy_q && cnt_q != '0) begin
			n_q <= {n_q[NW-2:0], 1'b0};
			if (!df[DW]) begin
				rem_q <= df;
				qt_q  <= {qt_q[NW-2:0], 1'b1};
			end else begin
				rem_q <= sh;
				qt_q  <= {qt_q[NW-2:0], 1'b0};
			end
		end
	end
endmodule
`default_nettype wire

// ----- rtl/ftsg_back.sv -----
`timescale 1ns / 1ps
`default_nettype none
module ftsg_back
	import ftsg_pkg::*;
#(
	parameter int MAX_ROWS  = 64,
	parameter int FRAC_BITS = 8
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          q_valid,
	output logic               q_take,
	input  wire tri_t          q_data,
	output logic               out_valid,
	input  wire logic          out_stall,
	output logic signed [SW-1:0] span_first,
	output logic signed [SW-1:0] span_stop,
	output logic [CW-1:0]      span_color,
	output logic               last_span
);
	localparam int NW = XW + 1 + FRAC_BITS;
	localparam int AW = 8 + YW + 2 + FRAC_BITS;
	localparam int RW = $clog2(MAX_ROWS + 1);

	bk_state_t state_q, state_d;
	tri_t      t_q;
	tri_t      tsrc;
	logic [1:0] dsel_q, dsel_n;
	logic signed [NW-1:0] s01_q, s02_q, s12_q, sl_q, sr_q, dq;
	logic signed [AW-1:0] l_q, r_q, nl, nr;
	logic [YW-1:0] n_q;
	logic [RW-1:0] cnt_q;
	logic upl_q, dstart, ddone, emit, fin_part, last;
	logic signed [NW-1:0] dnum;
	logic [YW-1:0] dden, dyu, dyl;
	logic signed [AW-1:0] rowc;

	assign rowc = AW'(256) <<< FRAC_BITS;

	// operands follow the division that starts this cycle
	always_comb begin
		tsrc = q_take ? q_data : t_q;
		if (q_take) dsel_n = 2'd0;
		else if (state_q == BK_DIV && ddone) dsel_n = dsel_q + 2'd1;
		else dsel_n = dsel_q;
		unique case (dsel_n)
			2'd0: begin
				dnum = NW'(($signed({1'b0, tsrc.bx}) - $signed({1'b0, tsrc.ax}))) <<< FRAC_BITS;
				dden = tsrc.by - tsrc.ay;
			end
			2'd1: begin
				dnum = NW'(($signed({1'b0, tsrc.cx}) - $signed({1'b0, tsrc.ax}))) <<< FRAC_BITS;
				dden = tsrc.cy - tsrc.ay;
			end
			default: begin
				dnum = NW'(($signed({1'b0, tsrc.cx}) - $signed({1'b0, tsrc.bx}))) <<< FRAC_BITS;
				dden = tsrc.cy - tsrc.by;
			end
		endcase
		if (dden == '0) dden = YW'(1);
	end

	ftsg_div #(.NW(NW), .DW(YW)) u_div (
		.clk(clk), .arst_n(arst_n), .start(dstart), .num(dnum), .den(dden),
		.done(ddone), .quo(dq)
	);

	assign dyu = (t_q.by == t_q.ay) ? YW'(1) : t_q.by - t_q.ay;
	assign dyl = (t_q.cy == t_q.by) ? YW'(1) : t_q.cy - t_q.by;
	assign nl  = l_q + rowc + AW'(sl_q);
	assign nr  = r_q + rowc + AW'(sr_q);

	assign emit     = (state_q == BK_UPPER || state_q == BK_LOWER) && !(out_valid && out_stall);
	assign fin_part = (n_q == YW'(1));
	assign last     = (cnt_q == RW'(MAX_ROWS - 1)) || (state_q == BK_LOWER && fin_part);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			BK_IDLE:  if (q_valid) state_d = BK_DIV;
			BK_DIV:   if (ddone && dsel_q == 2'd2) state_d = BK_PREP;
			BK_PREP:  state_d = BK_UPPER;
			BK_UPPER: if (emit) begin
				if (last) state_d = BK_IDLE;
				else if (fin_part) state_d = BK_LOWER;
			end
			BK_LOWER: if (emit && last) state_d = BK_IDLE;
			default:  state_d = BK_IDLE;
		endcase
	end

	always_comb begin
		q_take = (state_q == BK_IDLE) && q_valid;
		dstart = (state_q == BK_IDLE && q_valid) || (state_q == BK_DIV && ddone && dsel_q != 2'd2);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= BK_IDLE;
			out_valid <= 1'b0;
			dsel_q    <= 2'd0;
			cnt_q     <= '0;
		end else begin
			state_q <= state_d;
			if (emit) out_valid <= 1'b1;
			else if (!out_stall) out_valid <= 1'b0;
			if (q_take) begin
				dsel_q <= 2'd0;
				cnt_q  <= '0;
			end else if (state_q == BK_DIV && ddone) begin
				dsel_q <= dsel_q + 2'd1;
			end
			if (emit) cnt_q <= cnt_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (q_take) t_q <= q_data;
		if (state_q == BK_DIV && ddone) begin
			unique case (dsel_q)
				2'd0:    s01_q <= dq;
				2'd1:    s02_q <= dq;
				default: s12_q <= dq;
			endcase
		end
		if (state_q == BK_PREP) begin
			upl_q <= (s01_q < s02_q);
			sl_q  <= (s01_q < s02_q) ? s01_q : s02_q;
			sr_q  <= (s01_q < s02_q) ? s02_q : s01_q;
			l_q   <= AW'({t_q.ay, t_q.ax}) <<< FRAC_BITS;
			r_q   <= AW'({t_q.ay, t_q.ax}) <<< FRAC_BITS;
			n_q   <= dyu;
		end
		if (emit) begin
			l_q        <= nl;
			r_q        <= nr;
			span_first <= SW'(nl >>> (FRAC_BITS + 1));
			span_stop  <= SW'(nr >>> (FRAC_BITS + 1));
			span_color <= t_q.color;
			last_span  <= last;
			if (state_q == BK_UPPER && fin_part) begin
				n_q <= dyl;
				if (upl_q) sl_q <= s12_q;
				else       sr_q <= s12_q;
			end else begin
				n_q <= n_q - YW'(1);
			end
		end
	end

	a_emit_room: assert property (@(posedge clk) disable iff (!arst_n)
		emit |-> !(out_valid && out_stall)) else $error("span overwritten");
	a_take_idle: assert property (@(posedge clk) disable iff (!arst_n)
		q_take |-> state_q == BK_IDLE) else $error("take while busy");
	a_row_cap: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= RW'(MAX_ROWS)) else $error("row count exceeded");
endmodule
`default_nettype wire

// ----- rtl/flat_triangle_span_generator_top.sv -----
`timescale 1ns / 1ps
`default_nettype none
// Slope set-up: three serial slope divisions from triangle beat to first span,
//   one quotient bit per cycle in one shared divider.
// Throughput: one span beat per cycle while the receiver does not stall; the back
//   part takes the next triangle only after its last span. The front queue takes two triangles ahead.
// Reset: arst_n asynchronous, active low; clears queue and edge walker control.
module flat_triangle_span_generator_top
	import ftsg_pkg::*;
#(
	parameter int MAX_ROWS  = 64,
	parameter int FRAC_BITS = 8
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          in_valid,
	output logic               in_stall,
	input  wire logic [XW-1:0] vert0_x,
	input  wire logic [YW-1:0] vert0_y,
	input  wire logic [XW-1:0] vert1_x,
	input  wire logic [YW-1:0] vert1_y,
	input  wire logic [XW-1:0] vert2_x,
	input  wire logic [YW-1:0] vert2_y,
	input  wire logic [CW-1:0] fill_color,
	output logic               out_valid,
	input  wire logic          out_stall,
	output logic signed [SW-1:0] span_first,
	output logic signed [SW-1:0] span_stop,
	output logic [CW-1:0]      span_color,
	output logic               last_span
);
	// front sorts vertices by y and queues the beat
	logic q_valid, q_take;
	tri_t q_data;

	ftsg_front u_front (
		.clk, .arst_n, .in_valid, .in_stall,
		.vert0_x, .vert0_y, .vert1_x, .vert1_y, .vert2_x, .vert2_y, .fill_color,
		.q_valid, .q_take, .q_data
	);

	// back computes slopes and walks both edges, one span per row
	ftsg_back #(.MAX_ROWS(MAX_ROWS), .FRAC_BITS(FRAC_BITS)) u_back (
		.clk, .arst_n, .q_valid, .q_take, .q_data,
		.out_valid, .out_stall, .span_first, .span_stop, .span_color, .last_span
	);
endmodule
`default_nettype wire

// ----- tb/span_checker.sv -----
`timescale 1ns / 1ps
module span_checker
	import ftsg_pkg::*;
#(
	parameter int MAX_ROWS  = 64,
	parameter int FRAC_BITS = 8
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          in_valid,
	input  wire logic          in_stall,
	input  wire logic [XW-1:0] vert0_x,
	input  wire logic [YW-1:0] vert0_y,
	input  wire logic [XW-1:0] vert1_x,
	input  wire logic [YW-1:0] vert1_y,
	input  wire logic [XW-1:0] vert2_x,
	input  wire logic [YW-1:0] vert2_y,
	input  wire logic [CW-1:0] fill_color,
	input  wire logic          out_valid,
	input  wire logic          out_stall,
	input  wire logic signed [SW-1:0] span_first,
	input  wire logic signed [SW-1:0] span_stop,
	input  wire logic [CW-1:0] span_color,
	input  wire logic          last_span,
	output int                 fail_count,
	output int                 pending_spans,
	output int                 span_total
);
	typedef struct {
		logic signed [SW-1:0] first;
		logic signed [SW-1:0] stop;
		logic [CW-1:0]        color;
		logic                 last;
	} span_t;

	span_t expected_spans[$];

	function automatic longint slope(int dx, int dy);
		if (dy == 0)
			dy = 1;
		return (dx * (1 << FRAC_BITS)) / dy;
	endfunction

	task automatic push_span(inout int n, input longint l, input longint r,
			input logic [CW-1:0] color);
		span_t s;
		if (n >= MAX_ROWS)
			return;
		s.first = SW'(l >>> (FRAC_BITS + 1));
		s.stop  = SW'(r >>> (FRAC_BITS + 1));
		s.color = color;
		s.last  = 1'b0;
		expected_spans.push_back(s);
		n++;
	endtask

	task automatic rasterize(input int x[3], input int y[3], input logic [CW-1:0] color);
		int a, b, c, d01, d12, n, i, base;
		longint s01, s02, s12, sl, sr, l, r, row;
		logic upper_left;
		if (y[0] < y[1]) begin
			if (y[0] < y[2]) begin
				a = 0;
				if (y[1] < y[2]) begin b = 1; c = 2; end
				else begin b = 2; c = 1; end
			end else begin
				a = 2; b = 0; c = 1;
			end
		end else begin
			if (y[1] < y[2]) begin
				a = 1;
				if (y[0] < y[2]) begin b = 0; c = 2; end
				else begin b = 2; c = 0; end
			end else begin
				a = 2; b = 1; c = 0;
			end
		end
		d01 = (y[b] == y[a]) ? 1 : y[b] - y[a];
		d12 = (y[c] == y[b]) ? 1 : y[c] - y[b];
		s01 = slope(x[b] - x[a], y[b] - y[a]);
		s02 = slope(x[c] - x[a], y[c] - y[a]);
		s12 = slope(x[c] - x[b], y[c] - y[b]);
		upper_left = s01 < s02;
		sr = upper_left ? s02 : s01;
		sl = upper_left ? s01 : s02;
		row = longint'(256) << FRAC_BITS;
		l = (longint'(x[a]) + (longint'(y[a]) << 8)) << FRAC_BITS;
		r = l;
		n = 0;
		base = expected_spans.size();
		for (i = 0; i < d01; i++) begin
			r += row + sr;
			l += row + sl;
			push_span(n, l, r, color);
		end
		if (upper_left)
			sl = s12;
		else
			sr = s12;
		for (i = 0; i < d12; i++) begin
			r += row + sr;
			l += row + sl;
			push_span(n, l, r, color);
		end
		if (n > 0)
			expected_spans[base + n - 1].last = 1'b1;
	endtask

	always @(posedge clk or negedge arst_n) begin
		int x[3], y[3];
		span_t e;
		int errs;
		if (!arst_n) begin
			fail_count    <= 0;
			span_total    <= 0;
			pending_spans <= 0;
			expected_spans.delete();
		end else begin
			errs = 0;
			if (in_valid && !in_stall) begin
				x[0] = vert0_x; x[1] = vert1_x; x[2] = vert2_x;
				y[0] = vert0_y; y[1] = vert1_y; y[2] = vert2_y;
				rasterize(x, y, fill_color);
			end
			if (out_valid && !out_stall) begin
				span_total <= span_total + 1;
				if (expected_spans.size() == 0) begin
					$error("span beat with nothing expected");
					errs++;
				end else begin
					e = expected_spans.pop_front();
					if (span_first !== e.first) begin
						$error("span_first exp %0d got %0d", e.first, span_first);
						errs++;
					end
					if (span_stop !== e.stop) begin
						$error("span_stop exp %0d got %0d", e.stop, span_stop);
						errs++;
					end
					if (span_color !== e.color) begin
						$error("span_color exp %h got %h", e.color, span_color);
						errs++;
					end
					if (last_span !== e.last) begin
						$error("last_span exp %0b got %0b", e.last, last_span);
						errs++;
					end
				end
			end
			fail_count    <= fail_count + errs;
			pending_spans <= expected_spans.size();
		end
	end
endmodule

// ----- tb/tb_top.sv -----
`timescale 1ns / 1ps
module tb_top;
	import ftsg_pkg::*;

	logic          clk = 1'b0;
	logic          arst_n = 1'b0;
	// sender side
	logic          in_valid = 1'b0;
	logic          in_stall;
	logic [XW-1:0] vert0_x = '0, vert1_x = '0, vert2_x = '0;
	logic [YW-1:0] vert0_y = '0, vert1_y = '0, vert2_y = '0;
	logic [CW-1:0] fill_color = '0;
	// receiver side
	logic          out_valid;
	logic          out_stall = 1'b0;
	logic signed [SW-1:0] span_first, span_stop;
	logic [CW-1:0] span_color;
	logic          last_span;

	int fail_count, pending_spans, span_total;
	int tri_count = 0;
	bit calm = 1'b0;   // no idling / no stall while set

	flat_triangle_span_generator_top uut (.*);

	span_checker chk (.*);

	initial begin
		forever #2 clk = ~clk;
	end

	// receiver stalls ~9% of cycles except in the calm stretch
	always @(posedge clk) begin
		out_stall <= !calm && ($urandom_range(99) < 9);
	end

	// one triangle beat; random gap first, then hold until accepted
	task automatic send_tri(input logic [XW-1:0] x0, input logic [YW-1:0] y0,
			input logic [XW-1:0] x1, input logic [YW-1:0] y1,
			input logic [XW-1:0] x2, input logic [YW-1:0] y2,
			input logic [CW-1:0] color);
		while (!calm && $urandom_range(99) < 9) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid   <= 1'b1;
		vert0_x    <= x0; vert0_y <= y0;
		vert1_x    <= x1; vert1_y <= y1;
		vert2_x    <= x2; vert2_y <= y2;
		fill_color <= color;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		tri_count++;
	endtask

	// well-formed triangles mostly small; a few tall ones
	task automatic send_random;
		logic [YW-1:0] ybase;
		logic [YW-1:0] h;
		if ($urandom_range(9) == 0) begin
			send_tri(XW'($urandom), YW'($urandom), XW'($urandom), YW'($urandom),
				XW'($urandom), YW'($urandom), CW'($urandom));
		end else begin
			ybase = YW'($urandom);
			h = YW'($urandom_range(12));
			send_tri(XW'($urandom), ybase, XW'($urandom), ybase + YW'($urandom_range(h)),
				XW'($urandom), ybase + h, CW'($urandom));
		end
	endtask

	initial begin
		int i;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: corners, ties in every order, flat top/bottom, degenerate point
		send_tri(8'd0, 6'd0, 8'd0, 6'd0, 8'd0, 6'd0, 32'h0);
		send_tri(8'd255, 6'd63, 8'd255, 6'd63, 8'd255, 6'd63, 32'hFFFF_FFFF);
		send_tri(8'd0, 6'd0, 8'd255, 6'd63, 8'd128, 6'd32, 32'hA5A5_5A5A);
		send_tri(8'd255, 6'd0, 8'd0, 6'd63, 8'd0, 6'd0, 32'h5A5A_A5A5);
		send_tri(8'd10, 6'd5, 8'd200, 6'd5, 8'd100, 6'd40, 32'h1);
		send_tri(8'd100, 6'd40, 8'd10, 6'd5, 8'd200, 6'd5, 32'h2);
		send_tri(8'd200, 6'd5, 8'd100, 6'd40, 8'd10, 6'd40, 32'h3);
		send_tri(8'd50, 6'd20, 8'd60, 6'd10, 8'd70, 6'd20, 32'h4);
		send_tri(8'd50, 6'd30, 8'd60, 6'd30, 8'd70, 6'd10, 32'h5);
		send_tri(8'd0, 6'd1, 8'd255, 6'd0, 8'd0, 6'd2, 32'h8000_0000);
		send_tri(8'd255, 6'd2, 8'd0, 6'd1, 8'd255, 6'd0, 32'h7FFF_FFFF);
		send_tri(8'd0, 6'd63, 8'd255, 6'd0, 8'd0, 6'd0, 32'hDEAD_BEEF);
		send_tri(8'd128, 6'd0, 8'd0, 6'd63, 8'd255, 6'd63, 32'hCAFE_F00D);
		send_tri(8'd3, 6'd7, 8'd3, 6'd9, 8'd3, 6'd8, 32'h0F0F_0F0F);
		send_tri(8'd170, 6'd42, 8'd85, 6'd21, 8'd170, 6'd21, 32'hAAAA_5555);
		in_valid <= 1'b0;
		@(posedge clk);

		// drain fully before the random part
		while (pending_spans != 0)
			@(posedge clk);

		for (i = 0; i < 100; i++) begin
			calm = (i >= 40 && i < 60);
			send_random();
		end
		calm = 1'b0;
		in_valid <= 1'b0;
		@(posedge clk);

		while (pending_spans != 0)
			@(posedge clk);
		repeat (200) @(posedge clk);

		$display("%0d triangles sent, %0d spans checked incl. ties, flat edges, full height",
			tri_count, span_total);
		if (fail_count == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

	// watchdog: 115 triangles * ~64 spans with stalls fit far below this
	initial begin
		#2_000_000;
		$display("Test completed with failures");
		$finish;
	end
endmodule

// ----- flat_triangle_span_generator_top.f -----
rtl/ftsg_pkg.sv
rtl/ftsg_front.sv
rtl/ftsg_div.sv
rtl/ftsg_back.sv
rtl/flat_triangle_span_generator_top.sv
tb/span_checker.sv
tb/tb_top.sv
